### design/rtir_pkg.sv
// rtir_pkg: shared constants for the raster timing and interrupt register file
// action codes, special register addresses and frame geometry
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rtir_pkg;

    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 8;
    localparam int LINE_W   = 9;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

    // special register addresses
    localparam logic [ADDR_W-1:0] REG_CTRL       = 6'h11;
    localparam logic [ADDR_W-1:0] REG_RASTER     = 6'h12;
    localparam logic [ADDR_W-1:0] REG_PENDING    = 6'h19;
    localparam logic [ADDR_W-1:0] REG_ENABLE     = 6'h1A;
    localparam logic [ADDR_W-1:0] REG_BORDER     = 6'h20;
    localparam logic [ADDR_W-1:0] REG_BACKGROUND = 6'h21;

    // bit masks
    localparam logic [DATA_W-1:0] PEND_RASTER = 8'h01;
    localparam logic [DATA_W-1:0] PEND_IRQ    = 8'h80;
    localparam logic [DATA_W-1:0] COLOUR_MASK = 8'h0F;
    localparam logic [DATA_W-1:0] LOW7_MASK   = 8'h7F;
    localparam logic [DATA_W-1:0] UNMAPPED    = 8'hFF;

    // frame geometry and register file defaults
    localparam int CYCLES_PER_LINE_DEF = 63;
    localparam int REGISTER_COUNT_DEF  = 47;
    localparam logic [LINE_W-1:0] LINES_PER_FRAME = 9'd312;
    localparam logic [LINE_W-1:0] VISIBLE_LINES   = 9'd200;

endpackage
`default_nettype wire

### design/raster_timing_irq_regfile.sv
// raster_timing_irq_regfile: register file with cycle and raster line counters
// and a raster compare interrupt; depends on rtir_pkg
`timescale 1ns / 1ps
`default_nettype none
// One transfer in, one transfer out: every accepted item (tick, register read
// or register write) yields exactly one result in the next cycle, held in an
// output register until taken. A new item is accepted in every cycle in which
// the output register is empty or being emptied, so the block sustains one
// item per clock; the single output stage is what sets that figure. A tick
// steps the cycle counter; at the end of a line it raises render_line for
// visible lines, steps the raster line (frame_done on the wrap to zero) and
// compares the new line with {ctrl bit 7, raster compare byte}. A match sets
// pending bit 0 and, if pending AND enable is nonzero, pending bit 7 together
// with irq_request. Reads of the control and raster addresses return the live
// line; addresses at or above the register count read 0xFF and ignore writes.
// There is no clearing pass: ordinary registers carry one valid bit each, so
// the file reads as all zero straight after reset.
module raster_timing_irq_regfile #(
    parameter int CYCLES_PER_LINE = rtir_pkg::CYCLES_PER_LINE_DEF,
    parameter int REGISTER_COUNT  = rtir_pkg::REGISTER_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rtir_pkg::ACTION_W-1:0] action,
    input  wire logic [rtir_pkg::ADDR_W-1:0]   address,
    input  wire logic [rtir_pkg::DATA_W-1:0]   write_data,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [rtir_pkg::DATA_W-1:0]        read_data,
    output logic                               irq_request,
    output logic                               render_line,
    output logic                               frame_done,
    output logic [rtir_pkg::LINE_W-1:0]        current_line
);
    import rtir_pkg::*;

    localparam int CYC_W = $clog2(CYCLES_PER_LINE);
    localparam int MEM_W = $clog2(REGISTER_COUNT);
    localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(CYCLES_PER_LINE - 1);
    localparam logic [ADDR_W:0]  REG_LIMIT = (ADDR_W + 1)'(REGISTER_COUNT);

    // counters and dedicated registers
    logic [CYC_W-1:0]  cycle_reg, cycle_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [DATA_W-1:0] ctrl_reg, ctrl_next;
    logic [DATA_W-1:0] cmp_reg, cmp_next;
    logic [DATA_W-1:0] pend_reg, pend_next;
    logic [DATA_W-1:0] enable_reg, enable_next;

    // ordinary register storage, one valid bit per entry
    logic [DATA_W-1:0]         mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] mem_valid_reg;
    logic [DATA_W-1:0]         mem_rd_reg;

    // output stage
    logic              out_valid_reg;
    logic              use_mem_reg, use_mem_next;
    logic              mem_hit_reg;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic              irq_reg, irq_next;
    logic              render_reg, render_next;
    logic              frame_reg, frame_next;

    logic              accept;
    logic              in_range;
    logic              special;
    logic              mem_we;
    logic [MEM_W-1:0]  mem_idx;
    logic [DATA_W-1:0] mem_wdata;
    logic              line_end;
    logic              wrap;
    logic [DATA_W-1:0] pend_set;

    // the output register parts the two sides
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign in_range = {1'b0, address} < REG_LIMIT;
    assign special  = (address == REG_CTRL) || (address == REG_RASTER)
                   || (address == REG_PENDING) || (address == REG_ENABLE);
    assign mem_idx  = address[MEM_W-1:0];

    // colour registers keep four bits only
    assign mem_wdata = ((address == REG_BORDER) || (address == REG_BACKGROUND))
                     ? (write_data & COLOUR_MASK) : write_data;
    assign mem_we    = accept && (action == ACT_WRITE) && in_range && !special;

    assign line_end = (cycle_reg == CYC_LAST);
    assign wrap     = (line_reg == LINES_PER_FRAME - 9'd1);
    assign pend_set = pend_reg | PEND_RASTER;

    always_comb
    begin
        cycle_next   = cycle_reg;
        line_next    = line_reg;
        ctrl_next    = ctrl_reg;
        cmp_next     = cmp_reg;
        pend_next    = pend_reg;
        enable_next  = enable_reg;
        use_mem_next = 1'b0;
        rd_next      = '0;
        irq_next     = 1'b0;
        render_next  = 1'b0;
        frame_next   = 1'b0;
        unique case (action)
            ACT_TICK:
            begin
                if (line_end)
                begin
                    cycle_next  = '0;
                    render_next = (line_reg < VISIBLE_LINES);
                    frame_next  = wrap;
                    line_next   = wrap ? '0 : line_reg + 9'd1;
                    // compare on the new line only
                    if (line_next == {ctrl_reg[7], cmp_reg})
                    begin
                        pend_next = pend_set;
                        if ((pend_set & enable_reg) != '0)
                        begin
                            pend_next = pend_set | PEND_IRQ;
                            irq_next  = 1'b1;
                        end
                    end
                end
                else
                begin
                    cycle_next = cycle_reg + CYC_W'(1);
                end
            end
            ACT_READ:
            begin
                priority if (!in_range)
                    rd_next = UNMAPPED;
                else if (address == REG_CTRL)
                    rd_next = (ctrl_reg & LOW7_MASK) | {line_reg[8], 7'd0};
                else if (address == REG_RASTER)
                    rd_next = line_reg[DATA_W-1:0];
                else if (address == REG_PENDING)
                    rd_next = pend_reg;
                else if (address == REG_ENABLE)
                    rd_next = enable_reg;
                else
                    use_mem_next = 1'b1;
            end
            ACT_WRITE:
            begin
                if (in_range)
                begin
                    unique case (address)
                        REG_CTRL:    ctrl_next   = write_data;
                        REG_RASTER:  cmp_next    = write_data;
                        REG_PENDING: pend_next   = pend_reg & ~write_data;
                        REG_ENABLE:  enable_next = write_data;
                        default:     ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // control and dedicated state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg     <= '0;
            line_reg      <= '0;
            ctrl_reg      <= '0;
            cmp_reg       <= '0;
            pend_reg      <= '0;
            enable_reg    <= '0;
            mem_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cycle_reg  <= cycle_next;
                line_reg   <= line_next;
                ctrl_reg   <= ctrl_next;
                cmp_reg    <= cmp_next;
                pend_reg   <= pend_next;
                enable_reg <= enable_next;
            end
            if (mem_we)
                mem_valid_reg[mem_idx] <= 1'b1;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // register storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_idx] <= mem_wdata;
        if (accept && in_range)
            mem_rd_reg <= mem[mem_idx];
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            use_mem_reg <= use_mem_next;
            mem_hit_reg <= in_range && mem_valid_reg[mem_idx];
            rd_reg      <= rd_next;
            irq_reg     <= irq_next;
            render_reg  <= render_next;
            frame_reg   <= frame_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = use_mem_reg ? (mem_hit_reg ? mem_rd_reg : '0) : rd_reg;
    assign irq_request  = irq_reg;
    assign render_line  = render_reg;
    assign frame_done   = frame_reg;
    // line only moves on an accept, which also reloads the output stage
    assign current_line = line_reg;

    // cycle counter never reaches the line length
    a_cycle_range: assert property (@(posedge clk) disable iff (!rst_n)
        cycle_reg <= CYC_LAST)
        else $error("cycle counter out of range");

    // a raised interrupt leaves both pending bits set
    a_irq_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_request |-> pend_reg[0] && pend_reg[7])
        else $error("interrupt without pending bits");

    // a frame wrap reports line zero
    a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> current_line == '0)
        else $error("frame done on a nonzero line");

    // line counter stays inside the frame
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg < LINES_PER_FRAME)
        else $error("raster line out of range");

endmodule
`default_nettype wire

### tb/tb.sv
// tb: self-checking bench for raster_timing_irq_regfile, with a directed table,
// then randomised register traffic and tick runs across line ends, under random idling
// depends on rtir_pkg and the raster_timing_irq_regfile rtl
`timescale 1ns / 1ps
module tb;

    import rtir_pkg::*;

    // unused action code, the block must treat it as a no-op
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    // edges of the register file address space
    localparam logic [ADDR_W-1:0] LAST_REG  = ADDR_W'(REGISTER_COUNT_DEF - 1);
    localparam logic [ADDR_W-1:0] FIRST_GAP = ADDR_W'(REGISTER_COUNT_DEF);
    localparam logic [ADDR_W-1:0] TOP_ADDR  = 6'h3F;

    localparam int SCRIPT_ROWS  = 25;
    localparam int ITEM_GOAL    = 750;     // least number of input transfers in the whole run

    // one result transfer as the block should present it
    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic              irq;
        logic              render;
        logic              frame;
        logic [LINE_W-1:0] line;
    } regfile_reply_t;

    // one row of the directed script; typed rows carry their read byte, and
    // as they all sit at line zero the rest of the reply is zero
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [ADDR_W-1:0]   adr;
        logic [DATA_W-1:0]   wdat;
        logic                typed;
        logic [DATA_W-1:0]   rd;
    } script_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   write_data;
    logic                out_valid;
    logic                out_ready;
    logic [DATA_W-1:0]   read_data;
    logic                irq_request;
    logic                render_line;
    logic                frame_done;
    logic [LINE_W-1:0]   current_line;

    raster_timing_irq_regfile dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .address      (address),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .irq_request  (irq_request),
        .render_line  (render_line),
        .frame_done   (frame_done),
        .current_line (current_line)
    );

    // shadow copy of the register file and the two counters
    logic [DATA_W-1:0] reg_image [64];
    int                cycle_count;
    logic [LINE_W-1:0] line_now;

    // replies owed by the block, oldest first
    regfile_reply_t regfile_replies [$];

    script_row_t script [SCRIPT_ROWS];
    logic [ADDR_W-1:0] hot_regs [6];

    int  mismatches;
    int  n_items, n_access, n_ticks, n_reads, n_writes;
    int  n_hits, n_irqs, n_renders, n_wraps;
    bit  sender_calm;
    bit  rx_calm;
    int  rx_hold;
    int  rx_phase;

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #300_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // one line per mismatch, always counted
    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // stall or gap length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // advance the shadow block by one item and return the reply it owes
    function automatic regfile_reply_t step_raster_regfile(
        input logic [ACTION_W-1:0] act,
        input logic [ADDR_W-1:0]   adr,
        input logic [DATA_W-1:0]   wdat
    );
        regfile_reply_t r;
        logic [LINE_W-1:0] cmp;
        r = '0;
        case (act)
            ACT_TICK:
            begin
                n_ticks++;
                cycle_count++;
                // only the end of a line moves the raster and makes a compare
                if (cycle_count >= CYCLES_PER_LINE_DEF)
                begin
                    cycle_count = 0;
                    if (line_now < VISIBLE_LINES)
                        r.render = 1'b1;
                    line_now = line_now + 1'b1;
                    if (line_now >= LINES_PER_FRAME)
                    begin
                        line_now = '0;
                        r.frame = 1'b1;
                        n_wraps++;
                    end
                    // compare value: ctrl bit 7 on top of the raster byte
                    cmp = {reg_image[REG_CTRL][7], reg_image[REG_RASTER]};
                    if (line_now == cmp)
                    begin
                        n_hits++;
                        reg_image[REG_PENDING] = reg_image[REG_PENDING] | PEND_RASTER;
                        if ((reg_image[REG_PENDING] & reg_image[REG_ENABLE]) != '0)
                        begin
                            reg_image[REG_PENDING] = reg_image[REG_PENDING] | PEND_IRQ;
                            r.irq = 1'b1;
                            n_irqs++;
                        end
                    end
                    if (r.render)
                        n_renders++;
                end
            end
            ACT_READ:
            begin
                n_reads++;
                if (adr >= FIRST_GAP)
                    r.rd = UNMAPPED;
                else if (adr == REG_CTRL)
                    r.rd = {line_now[8], reg_image[REG_CTRL][6:0]};
                else if (adr == REG_RASTER)
                    r.rd = line_now[7:0];
                else
                    r.rd = reg_image[adr];
            end
            ACT_WRITE:
            begin
                n_writes++;
                if (adr >= FIRST_GAP)
                    ;
                else if (adr == REG_PENDING)
                    reg_image[adr] = reg_image[adr] & ~wdat;
                else if (adr == REG_BORDER || adr == REG_BACKGROUND)
                    reg_image[adr] = wdat & COLOUR_MASK;
                else
                    reg_image[adr] = wdat;
            end
            default:
                ;
        endcase
        r.line = line_now;
        return r;
    endfunction

    // offer one item, wait for its transfer, then book the reply it owes;
    // a typed reply replaces the shadow's one but the shadow still advances
    task automatic send_item(
        input logic [ACTION_W-1:0] act,
        input logic [ADDR_W-1:0]   adr,
        input logic [DATA_W-1:0]   wdat,
        input bit                  typed,
        input regfile_reply_t      given
    );
        int gap;
        regfile_reply_t owed;
        gap = (sender_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        address    <= adr;
        write_data <= wdat;
        // values seen here are those from before the edge
        do @(posedge clk); while (!in_ready);
        owed = step_raster_regfile(act, adr, wdat);
        regfile_replies.push_back(typed ? given : owed);
        n_items++;
    endtask

    // hold off the sender until every owed reply has been taken
    task automatic drain_replies();
        in_valid <= 1'b0;
        do @(posedge clk); while (regfile_replies.size() != 0);
    endtask

    // receiver: random stalls with calm stretches in between
    always @(posedge clk)
    begin
        if (rx_phase == 0)
        begin
            rx_calm  = !rx_calm;
            rx_phase = $urandom_range(50, 400);
        end
        else
            rx_phase--;
        if (rx_hold != 0)
        begin
            rx_hold--;
            out_ready <= 1'b0;
        end
        else if (!rx_calm && $urandom_range(0, 99) < 30)
        begin
            rx_hold = idle_len() - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // result checker: every transfer against the oldest owed reply
    always @(posedge clk)
    begin
        regfile_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (regfile_replies.size() == 0)
                flag_mismatch($sformatf("transfer with nothing owed, line %0d", current_line));
            else
            begin
                want = regfile_replies.pop_front();
                if (read_data !== want.rd)
                    flag_mismatch($sformatf("read_data %02h, want %02h", read_data, want.rd));
                if (irq_request !== want.irq)
                    flag_mismatch($sformatf("irq_request %b, want %b", irq_request, want.irq));
                if (render_line !== want.render)
                    flag_mismatch($sformatf("render_line %b, want %b", render_line, want.render));
                if (frame_done !== want.frame)
                    flag_mismatch($sformatf("frame_done %b, want %b", frame_done, want.frame));
                if (current_line !== want.line)
                    flag_mismatch($sformatf("current_line %0d, want %0d",
                                            current_line, want.line));
            end
        end
    end

    // stimulus
    initial
    begin
        int             kind;
        int             waited;
        logic [LINE_W-1:0] target;
        logic [DATA_W-1:0] en;
        regfile_reply_t given;
        logic [ACTION_W-1:0] act;
        logic [ADDR_W-1:0]   adr;

        // every input known from time zero
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_TICK;
        address     = '0;
        write_data  = '0;
        out_ready   = 1'b0;
        mismatches  = 0;
        n_items     = 0;
        n_access    = 0;
        n_ticks     = 0;
        n_reads     = 0;
        n_writes    = 0;
        n_hits      = 0;
        n_irqs      = 0;
        n_renders   = 0;
        n_wraps     = 0;
        sender_calm = 1'b0;
        rx_calm     = 1'b0;
        rx_hold     = 0;
        rx_phase    = 0;
        cycle_count = 0;
        line_now    = '0;
        foreach (reg_image[i])
            reg_image[i] = '0;

        hot_regs = '{REG_CTRL, REG_RASTER, REG_PENDING, REG_ENABLE, REG_BORDER,
                     REG_BACKGROUND};

        // directed script: act, address, data, typed, read byte when typed
        script = '{
            '{ACT_READ,  6'h00,          8'h00, 1'b1, 8'h00},     // file is zero after reset
            '{ACT_READ,  LAST_REG,       8'h00, 1'b1, 8'h00},     // last real register
            '{ACT_READ,  FIRST_GAP,      8'h00, 1'b1, UNMAPPED},  // first unmapped address
            '{ACT_READ,  TOP_ADDR,       8'h00, 1'b1, UNMAPPED},
            '{ACT_WRITE, LAST_REG,       8'hFF, 1'b0, 8'h00},
            '{ACT_READ,  LAST_REG,       8'h00, 1'b0, 8'h00},
            '{ACT_WRITE, TOP_ADDR,       8'hA5, 1'b1, 8'h00},     // write ignored
            '{ACT_READ,  TOP_ADDR,       8'h00, 1'b1, UNMAPPED},
            '{ACT_WRITE, REG_BORDER,     8'hFF, 1'b0, 8'h00},     // colour keeps four bits
            '{ACT_READ,  REG_BORDER,     8'h00, 1'b0, 8'h00},
            '{ACT_WRITE, REG_BACKGROUND, 8'hA7, 1'b0, 8'h00},
            '{ACT_READ,  REG_BACKGROUND, 8'h00, 1'b0, 8'h00},
            '{ACT_WRITE, REG_CTRL,       8'hFF, 1'b0, 8'h00},     // bit 7 reads live line
            '{ACT_READ,  REG_CTRL,       8'h00, 1'b0, 8'h00},
            '{ACT_WRITE, REG_RASTER,     8'h55, 1'b0, 8'h00},     // compare byte, not readable
            '{ACT_READ,  REG_RASTER,     8'h00, 1'b0, 8'h00},
            '{ACT_WRITE, REG_PENDING,    8'hFF, 1'b0, 8'h00},     // write-one-to-clear
            '{ACT_READ,  REG_PENDING,    8'h00, 1'b0, 8'h00},
            '{ACT_WRITE, REG_ENABLE,     8'h81, 1'b0, 8'h00},
            '{ACT_READ,  REG_ENABLE,     8'h00, 1'b0, 8'h00},
            '{ACT_TICK,  6'h00,          8'h00, 1'b0, 8'h00},     // tick inside a line
            '{ACT_NONE,  6'h2A,          8'h5A, 1'b1, 8'h00},     // unused action code
            '{ACT_READ,  6'h15,          8'hFF, 1'b0, 8'h00},     // data ignored on a read
            '{ACT_WRITE, REG_CTRL,       8'h00, 1'b0, 8'h00},
            '{ACT_WRITE, REG_RASTER,     8'h00, 1'b0, 8'h00}
        };

        // reset asserted from time zero, released once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            given    = '0;
            given.rd = script[i].rd;
            send_item(script[i].act, script[i].adr, script[i].wdat, script[i].typed, given);
        end
        // sender holds off until the block has answered everything
        drain_replies();

        // random part: compare set-ups that run the raster onto the target,
        // loose register traffic, and tick runs across line ends
        while (n_items < ITEM_GOAL)
        begin
            if ($urandom_range(0, 39) == 0)
                sender_calm = !sender_calm;
            if ($urandom_range(0, 59) == 0)
                drain_replies();
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                // raster compare on the next line, enable mostly on
                target = LINE_W'((int'(line_now) + 1) % int'(LINES_PER_FRAME));
                en = 8'($urandom());
                if ($urandom_range(0, 3) != 0)
                    en = en | PEND_RASTER;
                else
                    en = en & ~PEND_RASTER;
                send_item(ACT_WRITE, REG_ENABLE, en, 1'b0, '0);
                send_item(ACT_WRITE, REG_CTRL, {target[8], 7'($urandom())}, 1'b0, '0);
                send_item(ACT_WRITE, REG_RASTER, target[7:0], 1'b0, '0);
                n_access += 3;
                while (line_now != target)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        send_item(ACT_READ, hot_regs[$urandom_range(0, 5)], 8'($urandom()),
                                  1'b0, '0);
                        n_access++;
                    end
                    else
                        send_item(ACT_TICK, 6'($urandom()), 8'($urandom()), 1'b0, '0);
                end
                send_item(ACT_READ, REG_PENDING, 8'h00, 1'b0, '0);
                send_item(ACT_WRITE, REG_PENDING,
                          ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom()), 1'b0, '0);
                n_access += 2;
            end
            else if (kind < 75)
            begin
                // loose accesses, half of them on the special and colour registers
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: act = ACT_READ;
                        5, 6, 7, 8:    act = ACT_WRITE;
                        default:       act = ACT_NONE;
                    endcase
                    if ($urandom_range(0, 1) != 0)
                        adr = hot_regs[$urandom_range(0, 5)];
                    else
                        adr = 6'($urandom());
                    send_item(act, adr, 8'($urandom()), 1'b0, '0);
                    n_access++;
                end
            end
            else
            begin
                // free-running ticks
                repeat ($urandom_range(1, 100))
                    send_item(ACT_TICK, 6'($urandom()), 8'($urandom()), 1'b0, '0);
            end
        end

        // wait for the last replies, then idle on to catch anything stray
        in_valid <= 1'b0;
        waited = 0;
        while (regfile_replies.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (regfile_replies.size() != 0)
            flag_mismatch($sformatf("%0d replies never arrived", regfile_replies.size()));

        $display("run covered %0d transfers (%0d random accesses): %0d ticks, %0d reads, %0d writes",
                 n_items, n_access, n_ticks, n_reads, n_writes);
        $display("raster: %0d compare hits, %0d interrupts, %0d rendered lines, %0d frame wraps",
                 n_hits, n_irqs, n_renders, n_wraps);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
